@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// A condition that, when true, forces another one at the next clock edge.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/lrss_pkg.sv @@
package lrss_pkg;

  localparam int unsigned HeadW    = 16;
  localparam int unsigned ReflW    = 7;
  localparam int unsigned PowW     = 8;
  localparam int unsigned LimW     = 12;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 12;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 24;

  typedef enum logic [CfgIdxW-1:0] {
    REG_WHITE_LEVEL      = 3'd0,
    REG_BLACK_LEVEL      = 3'd1,
    REG_SWEEP_POWER      = 3'd2,
    REG_SWEEP_LIMIT      = 3'd3,
    REG_START_TURN_RIGHT = 3'd4
  } cfg_reg_e;

  // Line detector phases; the fourth code behaves like the first.
  localparam logic [1:0] PHASE_WHITE1 = 2'd0;
  localparam logic [1:0] PHASE_BLACK  = 2'd1;
  localparam logic [1:0] PHASE_WHITE2 = 2'd2;

  localparam logic [ReflW-1:0] WhiteLevelRst = 7'd50;
  localparam logic [ReflW-1:0] BlackLevelRst = 7'd10;
  localparam logic [ReflW-1:0] SweepPowerRst = 7'd45;
  localparam logic [LimW-1:0]  SweepLimitRst = 12'd900;
  localparam logic             TurnRightRst  = 1'b1;

  typedef struct packed {
    logic [ReflW-1:0] white_level;
    logic [ReflW-1:0] black_level;
    logic [ReflW-1:0] sweep_power;
    logic [LimW-1:0]  sweep_limit;
  } cfg_t;

  typedef struct packed {
    logic                    sweeping;
    logic                    turning_right;
    logic [1:0]              phase;
    logic signed [HeadW-1:0] last_heading;
    logic signed [HeadW-1:0] left_angle;
    logic signed [HeadW-1:0] right_angle;
  } state_t;

  typedef struct packed {
    logic                    edge_side;
    logic [ReflW-1:0]        reflect;
    logic signed [HeadW-1:0] heading;
  } item_t;

  typedef struct packed {
    logic                   recovered;
    logic                   drive_valid;
    logic signed [PowW-1:0] right_power;
    logic signed [PowW-1:0] left_power;
  } result_t;

endpackage

@@ rtl/core/lrss_step.sv @@
module lrss_step import lrss_pkg::*; (
  input  cfg_t    cfg_i,
  input  state_t  state_i,
  input  item_t   item_i,
  output state_t  state_o,
  output result_t result_o
);

  logic                    is_white;
  logic                    is_black;
  logic                    crossing;
  logic                    done;
  logic signed [HeadW:0]   diff;
  logic signed [HeadW-1:0] sat;
  logic signed [HeadW-1:0] limit_s;
  logic signed [PowW-1:0]  pw;

  assign is_white = item_i.reflect >= cfg_i.white_level;
  assign is_black = item_i.reflect <= cfg_i.black_level;
  assign pw       = {1'b0, cfg_i.sweep_power};
  assign limit_s  = {{(HeadW - LimW){1'b0}}, cfg_i.sweep_limit};

  // A right sweep grows with the heading, a left sweep shrinks with it.
  assign diff = state_i.turning_right
              ? ({item_i.heading[HeadW-1], item_i.heading}
                 - {state_i.last_heading[HeadW-1], state_i.last_heading})
              : ({state_i.last_heading[HeadW-1], state_i.last_heading}
                 - {item_i.heading[HeadW-1], item_i.heading});

  always_comb begin
    if (diff[HeadW] != diff[HeadW-1]) begin
      sat = diff[HeadW] ? {1'b1, {(HeadW - 1){1'b0}}} : {1'b0, {(HeadW - 1){1'b1}}};
    end else begin
      sat = diff[HeadW-1:0];
    end
  end

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    crossing = 1'b0;
    done     = 1'b0;
    if (!state_i.sweeping) begin
      state_o.last_heading = item_i.heading;
      state_o.left_angle   = limit_s;
      state_o.right_angle  = limit_s;
      state_o.phase        = PHASE_WHITE1;
      state_o.sweeping     = 1'b1;
    end else begin
      result_o.drive_valid = 1'b1;
      if (state_i.turning_right) begin
        result_o.left_power  = pw;
        result_o.right_power = -pw;
      end else begin
        result_o.left_power  = -pw;
        result_o.right_power = pw;
      end
      case (state_i.phase)
        PHASE_BLACK: begin
          if (is_black) state_o.phase = PHASE_WHITE2;
        end
        PHASE_WHITE2: begin
          if (is_white) begin
            state_o.phase = PHASE_WHITE1;
            crossing      = 1'b1;
          end
        end
        default: begin
          if (is_white) state_o.phase = PHASE_BLACK;
        end
      endcase
      if (crossing) begin
        if (state_i.turning_right) begin
          state_o.right_angle = sat;
        end else begin
          state_o.left_angle = sat;
        end
        state_o.last_heading  = item_i.heading;
        state_o.turning_right = !state_i.turning_right;
      end
      done = item_i.edge_side ? (state_o.right_angle < limit_s)
                              : (state_o.left_angle < limit_s);
      if (done) begin
        result_o.recovered = 1'b1;
        state_o.sweeping   = 1'b0;
      end
    end
  end

endmodule

@@ rtl/core/line_reacquire_sweep_sequencer_unit.sv @@
// Channel    Direction  Handshake                       Payload
// s_axis     in         s_axis_tvalid_i/s_axis_tready_o  heading, reflect, edge_side
// m_axis     out        m_axis_tvalid_o/m_axis_tready_i  left/right power, drive_valid,
//                                                        recovered
// cfg        in         cfg_we_i (no stall)              cfg_idx_i, cfg_wdata_i
//
// One request per cycle sustained while the output does not stall; a request passes the input register,
// then the combinational step logic and the result register.
// Reset is asynchronous and active low and needs no clearing pass.
// A stalled output holds the result register, and an empty input register takes one more
// request before s_axis_tready_o drops.
`include "assert_macros.svh"

module line_reacquire_sweep_sequencer_unit import lrss_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // heading[15:0], reflect[22:16], edge_side[23]
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // left_power[7:0], right_power[15:8], drive_valid[16], recovered[17], zeros[23:18]
  output logic [OutDataW-1:0] m_axis_tdata_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  cfg_t    cfg_q;
  state_t  state_d, state_q, state_next;
  item_t   item_q;
  result_t res_q, res_next;
  logic    in_valid_q;
  logic    out_valid_q;
  logic    advance;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OutDataW - $bits(result_t)){1'b0}}, res_q};

  lrss_step u_step (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .item_i   (item_q),
    .state_o  (state_next),
    .result_o (res_next)
  );

  always_comb begin
    state_d = advance ? state_next : state_q;
    if (cfg_we_i && (cfg_idx_i == REG_START_TURN_RIGHT)) begin
      state_d.turning_right = cfg_wdata_i[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.white_level     <= WhiteLevelRst;
      cfg_q.black_level     <= BlackLevelRst;
      cfg_q.sweep_power     <= SweepPowerRst;
      cfg_q.sweep_limit     <= SweepLimitRst;
      state_q.sweeping      <= 1'b0;
      state_q.turning_right <= TurnRightRst;
      state_q.phase         <= PHASE_WHITE1;
      state_q.last_heading  <= '0;
      state_q.left_angle    <= {{(HeadW - LimW){1'b0}}, SweepLimitRst};
      state_q.right_angle   <= {{(HeadW - LimW){1'b0}}, SweepLimitRst};
      in_valid_q            <= 1'b0;
      out_valid_q           <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_WHITE_LEVEL: cfg_q.white_level <= cfg_wdata_i[ReflW-1:0];
          REG_BLACK_LEVEL: cfg_q.black_level <= cfg_wdata_i[ReflW-1:0];
          REG_SWEEP_POWER: cfg_q.sweep_power <= cfg_wdata_i[ReflW-1:0];
          REG_SWEEP_LIMIT: cfg_q.sweep_limit <= cfg_wdata_i[LimW-1:0];
          default: ;
        endcase
      end
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      item_q <= s_axis_tdata_i[$bits(item_t)-1:0];
    end
    if (advance) begin
      res_q <= res_next;
    end
  end

  `ASSERT_ALWAYS(a_init_quiet, !out_valid_q || res_q.drive_valid || (res_q.left_power == '0 && res_q.right_power == '0 && !res_q.recovered), "init result drives motors")
  `ASSERT_NEXT(a_recover_rearms, advance && res_next.recovered, !state_q.sweeping, "recovery did not rearm the init tick")
  `ASSERT_NEXT(a_init_starts, advance && !state_q.sweeping, state_q.sweeping && res_q.drive_valid == 1'b0, "init tick did not start the sweep")
  `ASSERT_ALWAYS(a_no_result_loss, !(advance && out_valid_q && !m_axis_tready_i), "result register overwritten while stalled")

endmodule
